// ===== design/fmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmsp_pkg
// Types and constants for the file mode string parser.
// ----------------------------------------------------------------------------
package fmsp_pkg;

	typedef struct packed {
		logic [7:0]  char_code;
		logic        first_char;
		logic        last_char;
		logic [11:0] file_perm;
		logic        file_is_dir;
	} in_item_t;

	typedef struct packed {
		logic [11:0] new_mode;
		logic [2:0]  status;
	} out_item_t;

	// parse phases
	localparam logic [1:0] PH_WHO_IDLE = 2'd0;
	localparam logic [1:0] PH_WHO_BUSY = 2'd1;
	localparam logic [1:0] PH_PERM     = 2'd2;
	localparam logic [1:0] PH_OCTAL    = 2'd3;

	// pending operations
	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_SET    = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_ASSIGN = 2'd3;

	// who class bits
	localparam logic [2:0] WHO_U = 3'b001;
	localparam logic [2:0] WHO_G = 3'b010;
	localparam logic [2:0] WHO_O = 3'b100;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_WHO   = 3'd1;
	localparam logic [2:0] ST_PERM  = 3'd2;
	localparam logic [2:0] ST_DIGIT = 3'd3;
	localparam logic [2:0] ST_RANGE = 3'd4;

	// register indexes
	localparam logic REG_CREATION_MASK = 1'b0;
	localparam logic REG_STRICT_POSIX  = 1'b1;

	localparam logic [12:0] STRICT_LIMIT = 13'o6777;
	localparam logic [12:0] FULL_LIMIT   = 13'o7777;
	localparam logic [12:0] OCTAL_BOUND  = 13'd512;

	// characters
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_W     = 8'h77;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_XU    = 8'h58;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COMMA = 8'h2C;

endpackage

// ===== design/file_mode_string_parser.sv =====
// ----------------------------------------------------------------------------
// file_mode_string_parser
// Parses an octal or symbolic permission-mode string, one character per
// item, into a 12-bit mode and a status. The parse state updates at the
// edge that accepts an item and the result of a last character is loaded
// into an output register, so the block takes one item every cycle while
// in_ready is high, and a result appears in the cycle after its last
// character is accepted. in_ready drops only while the output register
// holds a result that is not taken. Configuration is written over an
// APB-style port: creation_mask at 0x0, strict_posix at 0x4.
// ----------------------------------------------------------------------------
module file_mode_string_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  fmsp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output fmsp_pkg::out_item_t out_item
);

	logic [8:0]  creation_mask_q;
	logic        strict_posix_q;

	logic [1:0]  phase_q, phase_d;
	logic [2:0]  who_q, who_d;
	logic [1:0]  op_q, op_d;
	logic [11:0] mode_q, mode_d;
	logic [12:0] octal_q, octal_d;
	logic [2:0]  err_q, err_d;
	logic [11:0] orig_q, orig_d;
	logic        orig_dir_q, orig_dir_d;

	logic        out_valid_q;
	fmsp_pkg::out_item_t out_item_q, result_d;

	logic        in_acc;
	logic        cfg_wr;
	logic [7:0]  ch;
	logic        is_digit;
	logic        is_ext;
	logic        do_apply;
	logic [2:0]  app_who;
	logic [11:0] pa, pb, pc, pabc, sel_bits;
	logic [11:0] t_bits;
	logic [11:0] res_mode;
	logic [12:0] limit;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign ch       = in_item.char_code;
	assign is_digit = (ch >= fmsp_pkg::CH_0) && (ch <= fmsp_pkg::CH_7);
	assign is_ext   = (ch == fmsp_pkg::CH_XU) || (ch == fmsp_pkg::CH_T) ||
		(ch == fmsp_pkg::CH_U) || (ch == fmsp_pkg::CH_G) || (ch == fmsp_pkg::CH_O);

	always_comb begin
		prdata = '0;
		if (paddr[2] == fmsp_pkg::REG_STRICT_POSIX) begin
			prdata = {31'd0, strict_posix_q};
		end else begin
			prdata = {23'd0, creation_mask_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			creation_mask_q <= 9'd18;
			strict_posix_q  <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == fmsp_pkg::REG_STRICT_POSIX) begin
				strict_posix_q <= pwdata[0];
			end else begin
				creation_mask_q <= pwdata[8:0];
			end
		end
	end

	// next parse state for the item at the input
	always_comb begin
		if (in_item.first_char) begin
			phase_d    = is_digit ? fmsp_pkg::PH_OCTAL : fmsp_pkg::PH_WHO_IDLE;
			who_d      = '0;
			op_d       = fmsp_pkg::OP_NONE;
			mode_d     = in_item.file_perm;
			octal_d    = '0;
			err_d      = fmsp_pkg::ST_OK;
			orig_d     = in_item.file_perm;
			orig_dir_d = in_item.file_is_dir;
		end else begin
			phase_d    = phase_q;
			who_d      = who_q;
			op_d       = op_q;
			mode_d     = mode_q;
			octal_d    = octal_q;
			err_d      = err_q;
			orig_d     = orig_q;
			orig_dir_d = orig_dir_q;
		end

		do_apply = 1'b0;
		app_who  = who_d;
		pa       = '0;
		pb       = '0;
		pc       = '0;
		t_bits   = '0;

		if (err_d == fmsp_pkg::ST_OK) begin
			case (phase_d)
				fmsp_pkg::PH_OCTAL: begin
					if (octal_d >= fmsp_pkg::OCTAL_BOUND || !is_digit) begin
						err_d = fmsp_pkg::ST_DIGIT;
					end else begin
						octal_d = {octal_d[9:0], ch[2:0]};
					end
				end
				fmsp_pkg::PH_PERM: begin
					if (is_ext && strict_posix_q) begin
						err_d = fmsp_pkg::ST_PERM;
					end else begin
						do_apply = 1'b1;
						case (ch)
							fmsp_pkg::CH_R: begin
								pa = 12'o0400; pb = 12'o0040; pc = 12'o0004;
							end
							fmsp_pkg::CH_W: begin
								pa = 12'o0200; pb = 12'o0020; pc = 12'o0002;
							end
							fmsp_pkg::CH_X: begin
								pa = 12'o0100; pb = 12'o0010; pc = 12'o0001;
							end
							fmsp_pkg::CH_S: begin
								pa = 12'o4000; pb = 12'o2000;
							end
							fmsp_pkg::CH_XU: begin
								// only with + on a directory or an already executable file
								if (op_d == fmsp_pkg::OP_SET &&
										(orig_dir_d || (orig_d & 12'o0111) != '0)) begin
									pa = 12'o0100; pb = 12'o0010; pc = 12'o0001;
								end
							end
							fmsp_pkg::CH_T: begin
								// o alone leaves the sticky bit untouched
								if (who_d == '0 || (who_d & (fmsp_pkg::WHO_U | fmsp_pkg::WHO_G)) != '0) begin
									app_who = fmsp_pkg::WHO_O;
									pc      = 12'o1000;
								end
							end
							fmsp_pkg::CH_U: begin
								t_bits  = orig_d & 12'o0700;
								pa      = t_bits;
								pb      = t_bits >> 3;
								pc      = t_bits >> 6;
								phase_d = fmsp_pkg::PH_WHO_IDLE;
							end
							fmsp_pkg::CH_G: begin
								t_bits  = orig_d & 12'o0070;
								pa      = t_bits << 3;
								pb      = t_bits;
								pc      = t_bits >> 3;
								phase_d = fmsp_pkg::PH_WHO_IDLE;
							end
							fmsp_pkg::CH_O: begin
								t_bits  = orig_d & 12'o0007;
								pa      = t_bits << 6;
								pb      = t_bits << 3;
								pc      = t_bits;
								phase_d = fmsp_pkg::PH_WHO_IDLE;
							end
							fmsp_pkg::CH_COMMA: begin
								do_apply = 1'b0;
								who_d    = '0;
								phase_d  = fmsp_pkg::PH_WHO_IDLE;
							end
							default: begin
								do_apply = 1'b0;
								err_d    = fmsp_pkg::ST_PERM;
							end
						endcase
					end
				end
				default: begin
					case (ch)
						fmsp_pkg::CH_U: begin
							who_d   = who_d | fmsp_pkg::WHO_U;
							phase_d = fmsp_pkg::PH_WHO_BUSY;
						end
						fmsp_pkg::CH_G: begin
							who_d   = who_d | fmsp_pkg::WHO_G;
							phase_d = fmsp_pkg::PH_WHO_BUSY;
						end
						fmsp_pkg::CH_O: begin
							who_d   = who_d | fmsp_pkg::WHO_O;
							phase_d = fmsp_pkg::PH_WHO_BUSY;
						end
						fmsp_pkg::CH_A: begin
							who_d   = fmsp_pkg::WHO_U | fmsp_pkg::WHO_G | fmsp_pkg::WHO_O;
							phase_d = fmsp_pkg::PH_WHO_BUSY;
						end
						fmsp_pkg::CH_PLUS: begin
							op_d    = fmsp_pkg::OP_SET;
							phase_d = fmsp_pkg::PH_PERM;
						end
						fmsp_pkg::CH_MINUS: begin
							op_d    = fmsp_pkg::OP_CLEAR;
							phase_d = fmsp_pkg::PH_PERM;
						end
						fmsp_pkg::CH_EQ: begin
							op_d    = fmsp_pkg::OP_ASSIGN;
							phase_d = fmsp_pkg::PH_PERM;
							if (who_d[0]) mode_d = mode_d & ~12'o4700;
							if (who_d[1]) mode_d = mode_d & ~12'o2070;
							if (who_d[2]) mode_d = mode_d & ~12'o1007;
							if (who_d == '0) mode_d = '0;
						end
						default: begin
							err_d = fmsp_pkg::ST_WHO;
						end
					endcase
				end
			endcase
		end

		// apply the class bits of a perm letter
		pabc     = pa | pb | pc;
		sel_bits = '0;
		if (app_who[0]) sel_bits = sel_bits | pa;
		if (app_who[1]) sel_bits = sel_bits | pb;
		if (app_who[2]) sel_bits = sel_bits | pc;
		if (do_apply) begin
			if (op_d != fmsp_pkg::OP_CLEAR) begin
				if (app_who == '0) begin
					mode_d = mode_d | (pabc & ~{3'b000, creation_mask_q});
				end else begin
					mode_d = mode_d | sel_bits;
				end
			end else begin
				if (app_who == '0) begin
					mode_d = mode_d & ~pabc;
				end else begin
					mode_d = mode_d & ~sel_bits;
				end
			end
		end

		// end-of-string checks; a late error stays recorded
		limit    = strict_posix_q ? fmsp_pkg::STRICT_LIMIT : fmsp_pkg::FULL_LIMIT;
		res_mode = mode_d;
		if (in_item.last_char && err_d == fmsp_pkg::ST_OK) begin
			if (phase_d == fmsp_pkg::PH_OCTAL) begin
				if ((octal_d & ~limit) != '0) begin
					err_d = fmsp_pkg::ST_RANGE;
				end else begin
					res_mode = octal_d[11:0];
				end
			end else if (phase_d == fmsp_pkg::PH_WHO_BUSY) begin
				err_d = fmsp_pkg::ST_WHO;
			end
		end
		if (err_d != fmsp_pkg::ST_OK) res_mode = '0;
		result_d.new_mode = res_mode;
		result_d.status   = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= fmsp_pkg::PH_WHO_IDLE;
			who_q      <= '0;
			op_q       <= fmsp_pkg::OP_NONE;
			mode_q     <= '0;
			octal_q    <= '0;
			err_q      <= fmsp_pkg::ST_OK;
			orig_q     <= '0;
			orig_dir_q <= 1'b0;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			who_q      <= who_d;
			op_q       <= op_d;
			mode_q     <= mode_d;
			octal_q    <= octal_d;
			err_q      <= err_d;
			orig_q     <= orig_d;
			orig_dir_q <= orig_dir_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && in_item.last_char) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_item.last_char) begin
			out_item_q <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// a failed result never carries a mode
	a_err_zero_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != fmsp_pkg::ST_OK |-> out_item.new_mode == '0)
		else $error("nonzero mode with error status");

	// a recorded error is kept until a new string starts
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != fmsp_pkg::ST_OK && !(in_acc && in_item.first_char) |=> err_q == $past(err_q))
		else $error("recorded error changed without restart");

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q && !out_ready)
		else $error("input stalled with free output register");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		err_q <= fmsp_pkg::ST_RANGE)
		else $error("status code out of range");

endmodule

// ===== bench/tb_file_mode_string_parser.sv =====
// ----------------------------------------------------------------------------
// tb_file_mode_string_parser
// Self-checking bench for the permission-mode string parser. Mode strings
// (octal, symbolic, malformed and raw noise) are streamed in one character
// per item. A scoreboard carries its own parser and checks every result
// against it. The bench steps through several creation-mask and strict
// settings, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_file_mode_string_parser;
	import fmsp_pkg::*;

	localparam logic [7:0] CH_NUL = 8'h00;

	class mode_scoreboard;
		logic [8:0]  creation_mask;
		logic        strict_posix;
		logic [1:0]  phase;
		logic [2:0]  who;
		logic [1:0]  op;
		logic [11:0] mode;
		logic [12:0] octal;
		logic [2:0]  err;
		logic [11:0] orig_perm;
		logic        orig_dir;
		out_item_t   awaited_modes[$];
		int          failures;
		int          chars_seen;
		int          results_checked;

		function new();
			creation_mask   = 9'd18;
			strict_posix    = 1'b0;
			phase           = PH_WHO_IDLE;
			who             = '0;
			op              = OP_NONE;
			mode            = '0;
			octal           = '0;
			err             = ST_OK;
			orig_perm       = '0;
			orig_dir        = 1'b0;
			failures        = 0;
			chars_seen      = 0;
			results_checked = 0;
		endfunction

		function void set_register(logic idx, logic [31:0] value);
			if (idx == REG_CREATION_MASK) begin
				creation_mask = value[8:0];
			end else begin
				strict_posix = value[0];
			end
		endfunction

		function int awaiting();
			return awaited_modes.size();
		endfunction

		function void apply_bits(logic [11:0] a, logic [11:0] b, logic [11:0] c, logic [2:0] w);
			if (op != OP_CLEAR) begin
				if ((w & WHO_U) != 0) mode |= a;
				if ((w & WHO_G) != 0) mode |= b;
				if ((w & WHO_O) != 0) mode |= c;
				// the mask only covers the nine rwx bits
				if (w == 3'b000) mode |= (a | b | c) & ~{3'b000, creation_mask};
			end else begin
				if ((w & WHO_U) != 0) mode &= ~a;
				if ((w & WHO_G) != 0) mode &= ~b;
				if ((w & WHO_O) != 0) mode &= ~c;
				if (w == 3'b000) mode &= ~(a | b | c);
			end
		endfunction

		function void perm_char(logic [7:0] ch);
			logic [2:0]  w;
			logic [11:0] a, b, c, t;
			logic        ext;
			w = who;
			a = '0;
			b = '0;
			c = '0;
			t = '0;
			ext = (ch == CH_XU) || (ch == CH_T) || (ch == CH_U) || (ch == CH_G) || (ch == CH_O);
			if (ext && strict_posix) begin
				err = ST_PERM;
				return;
			end
			case (ch)
			CH_R: begin
				a = 12'o400; b = 12'o040; c = 12'o004;
			end
			CH_W: begin
				a = 12'o200; b = 12'o020; c = 12'o002;
			end
			CH_X: begin
				a = 12'o100; b = 12'o010; c = 12'o001;
			end
			CH_S: begin
				a = 12'o4000; b = 12'o2000;
			end
			CH_XU: begin
				if (op == OP_SET && (orig_dir || (orig_perm & 12'o111) != 0)) begin
					a = 12'o100; b = 12'o010; c = 12'o001;
				end
			end
			CH_T: begin
				// sticky is ignored for "o" alone
				if (w == 3'b000 || (w & (WHO_U | WHO_G)) != 0) begin
					w = WHO_O;
					c = 12'o1000;
				end
			end
			CH_U: begin
				t = orig_perm & 12'o700; a = t; b = t >> 3; c = t >> 6;
			end
			CH_G: begin
				t = orig_perm & 12'o070; a = t << 3; b = t; c = t >> 3;
			end
			CH_O: begin
				t = orig_perm & 12'o007; a = t << 6; b = t << 3; c = t;
			end
			CH_COMMA: begin
				who = '0;
				phase = PH_WHO_IDLE;
				return;
			end
			default: begin
				err = ST_PERM;
				return;
			end
			endcase
			apply_bits(a, b, c, w);
			// copying a class ends the clause, who stays for the next op
			if (ch == CH_U || ch == CH_G || ch == CH_O) phase = PH_WHO_IDLE;
		endfunction

		function void who_char(logic [7:0] ch);
			case (ch)
			CH_U: begin
				who |= WHO_U; phase = PH_WHO_BUSY;
			end
			CH_G: begin
				who |= WHO_G; phase = PH_WHO_BUSY;
			end
			CH_O: begin
				who |= WHO_O; phase = PH_WHO_BUSY;
			end
			CH_A: begin
				who = WHO_U | WHO_G | WHO_O; phase = PH_WHO_BUSY;
			end
			CH_PLUS: begin
				op = OP_SET; phase = PH_PERM;
			end
			CH_MINUS: begin
				op = OP_CLEAR; phase = PH_PERM;
			end
			CH_EQ: begin
				op = OP_ASSIGN;
				phase = PH_PERM;
				if ((who & WHO_U) != 0) mode &= ~12'o4700;
				if ((who & WHO_G) != 0) mode &= ~12'o2070;
				if ((who & WHO_O) != 0) mode &= ~12'o1007;
				if (who == 3'b000) mode = '0;
			end
			default: err = ST_WHO;
			endcase
		endfunction

		function void note_char(in_item_t it);
			out_item_t   res;
			logic [12:0] limit;
			chars_seen++;
			if (it.first_char) begin
				orig_perm = it.file_perm;
				orig_dir  = it.file_is_dir;
				err       = ST_OK;
				who       = '0;
				op        = OP_NONE;
				octal     = '0;
				mode      = it.file_perm;
				phase     = (it.char_code >= CH_0 && it.char_code <= CH_7) ? PH_OCTAL : PH_WHO_IDLE;
			end
			if (err == ST_OK) begin
				if (phase == PH_OCTAL) begin
					if (octal >= OCTAL_BOUND || it.char_code < CH_0 || it.char_code > CH_7) begin
						err = ST_DIGIT;
					end else begin
						octal = (octal << 3) + (it.char_code - CH_0);
					end
				end else if (phase == PH_PERM) begin
					perm_char(it.char_code);
				end else begin
					who_char(it.char_code);
				end
			end
			if (!it.last_char) return;
			res.new_mode = mode;
			if (err == ST_OK) begin
				if (phase == PH_OCTAL) begin
					limit = strict_posix ? STRICT_LIMIT : FULL_LIMIT;
					if ((octal & ~limit) != 0) err = ST_RANGE;
					else res.new_mode = octal[11:0];
				end else if (phase == PH_WHO_BUSY) begin
					err = ST_WHO;
				end
			end
			if (err != ST_OK) res.new_mode = '0;
			res.status = err;
			awaited_modes.push_back(res);
		endfunction

		function void flag(string what, out_item_t want, out_item_t got);
			failures++;
			if (failures <= 10) begin
				$display("[%0t] %s: expected mode %04o status %0d, got mode %04o status %0d",
					$time, what, want.new_mode, want.status, got.new_mode, got.status);
			end
		endfunction

		function void check_mode(out_item_t got);
			out_item_t want;
			results_checked++;
			if (awaited_modes.size() == 0) begin
				flag("result with none pending", '0, got);
				return;
			end
			want = awaited_modes.pop_front();
			if (got.new_mode !== want.new_mode || got.status !== want.status) begin
				flag("mode mismatch", want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;

	mode_scoreboard sb = new();
	logic [7:0]     text[$];
	bit             no_idle;
	bit             stall_request;
	int             sent_chars;
	int             sent_strings;

	file_mode_string_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// results first: a result never belongs to an item taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_mode(out_item);
			if (in_valid && in_ready) sb.note_char(in_item);
		end
	end

	initial begin : receiver
		int held;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				out_ready <= 1'b0;
				held = 0;
				while (held < 80) begin
					@(posedge clk);
					held++;
				end
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= 28);
			end
		end
	end

	initial begin : watchdog
		#400000;
		$display("run timed out");
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] pick_who();
		case ($urandom_range(3))
		0: return CH_U;
		1: return CH_G;
		2: return CH_O;
		default: return CH_A;
		endcase
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(2))
		0: return CH_PLUS;
		1: return CH_MINUS;
		default: return CH_EQ;
		endcase
	endfunction

	function automatic logic [7:0] pick_bit_perm();
		case ($urandom_range(5))
		0: return CH_R;
		1: return CH_W;
		2: return CH_X;
		3: return CH_S;
		4: return CH_XU;
		default: return CH_T;
		endcase
	endfunction

	function automatic logic [7:0] pick_class_perm();
		case ($urandom_range(2))
		0: return CH_U;
		1: return CH_G;
		default: return CH_O;
		endcase
	endfunction

	// clauses like "ug+rw,o=u+x," with the occasional missing who
	function automatic void gen_symbolic();
		int clauses, nwho, nops;
		clauses = $urandom_range(1, 3);
		for (int k = 0; k < clauses; k++) begin
			if (k > 0) text.push_back(CH_COMMA);
			nwho = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3);
			repeat (nwho) text.push_back(pick_who());
			nops = ($urandom_range(4) == 0) ? 2 : 1;
			for (int p = 0; p < nops; p++) begin
				text.push_back(pick_op());
				repeat ($urandom_range(0, 3)) text.push_back(pick_bit_perm());
				if (p + 1 < nops || $urandom_range(3) == 0) text.push_back(pick_class_perm());
			end
		end
		if ($urandom_range(9) == 0) text.push_back(CH_COMMA);
	endfunction

	function automatic void gen_octal();
		int len;
		len = $urandom_range(1, 5);
		if ($urandom_range(3) == 0) begin
			// sticky bit set, out of range in strict mode
			len = 4;
			text.push_back(CH_0 + 8'd1);
		end else begin
			text.push_back(CH_0 + 8'($urandom_range(7)));
		end
		while (text.size() < len) text.push_back(CH_0 + 8'($urandom_range(7)));
		if ($urandom_range(7) == 0) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
	endfunction

	function automatic void gen_broken();
		gen_symbolic();
		if ($urandom_range(1) == 0) begin
			text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
		end else begin
			// ends in who letters with no op
			text.push_back(CH_COMMA);
			repeat ($urandom_range(1, 2)) text.push_back(pick_who());
		end
	endfunction

	task automatic send_text(bit mark_first, bit mark_last);
		in_item_t it;
		for (int i = 0; i < text.size(); i++) begin
			it.char_code   = text[i];
			it.first_char  = mark_first && (i == 0);
			it.last_char   = mark_last && (i == text.size() - 1);
			it.file_perm   = 12'($urandom_range(4095));
			it.file_is_dir = 1'($urandom_range(1));
			while (!no_idle && $urandom_range(99) < 28) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_item  <= it;
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			sent_chars++;
		end
		sent_strings++;
	endtask

	task automatic send_str(string s);
		text.delete();
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
		send_text(1'b1, 1'b1);
	endtask

	task automatic apb_write(logic idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_register(idx, value);
		// idle the bus so a following write starts on a later edge
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaiting() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic run_strings(int n_chars);
		int start, pick;
		start = sent_chars;
		while (sent_chars - start < n_chars) begin
			text.delete();
			pick = $urandom_range(99);
			if (pick < 45) gen_symbolic();
			else if (pick < 70) gen_octal();
			else if (pick < 85) gen_broken();
			else repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(255)));
			// now and then a string runs on without a start or an end mark
			send_text($urandom_range(19) != 0, $urandom_range(19) != 0);
		end
	endtask

	initial begin : stimulus
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		in_item       = '0;
		no_idle       = 1'b0;
		stall_request = 1'b0;
		sent_chars    = 0;
		sent_strings  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings at reset settings
		send_str("=rwx");
		send_str("u+g+r");
		send_str("o+t");
		send_str("+X");
		send_str("ug");
		send_str("10000");
		send_str("7z");
		text.delete();
		text.push_back(CH_NUL);
		send_text(1'b1, 1'b1);
		settle();

		apb_write(REG_CREATION_MASK, 32'($urandom_range(511)));
		apb_write(REG_STRICT_POSIX, 32'd0);
		run_strings(190);
		settle();

		apb_write(REG_CREATION_MASK, 32'd0);
		apb_write(REG_STRICT_POSIX, 32'd1);
		stall_request = 1'b1;
		run_strings(190);
		settle();

		apb_write(REG_CREATION_MASK, 32'd511);
		apb_write(REG_STRICT_POSIX, 32'd0);
		no_idle = 1'b1;
		run_strings(190);
		settle();
		no_idle = 1'b0;

		apb_write(REG_CREATION_MASK, 32'($urandom_range(511)));
		apb_write(REG_STRICT_POSIX, 32'd1);
		run_strings(190);
		settle();

		if (sb.awaiting() != 0) sb.failures++;
		$display("sent %0d characters in %0d strings, checked %0d modes, %0d failures",
			sent_chars, sent_strings, sb.results_checked, sb.failures);
		$display("masks 0/511/random, strict off and on, one long output stall");
		if (sb.failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
